// ===== hw/rtl/closest_point_on_segment_defines.svh =====
// assertion macros for the closest point on segment block
// used by the top level; expects clk_i and rst_ni in scope
`ifndef CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cps assertion failed");
`define CPS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cps assertion failed");
`else
`define CPS_ASSERT(lbl, prop)
`define CPS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/cps_pkg.sv =====
// shared widths, stage types and helpers for the closest point on segment block
// no dependencies
`timescale 1ns / 1ps
package cps_pkg;
  localparam int CW    = 16;
  localparam int MDW   = 16;
  localparam int DW    = CW + 1;
  localparam int NW    = 2 * CW + 3;
  localparam int DENW  = 2 * CW + 1;
  localparam int PW    = DENW + CW;
  localparam int DISTW = 2 * CW + 1;
  localparam int RW    = 2 * MDW;
  localparam int CMPW  = (DISTW > RW) ? DISTW : RW;
  localparam int NFRONT = 4;
  localparam int NBACK  = 3;
  localparam int NST    = NFRONT + CW + NBACK;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_MID   = 2'd2;

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic [CW-1:0] qx;
    logic [CW-1:0] qy;
  } pts_t;

  typedef struct packed {
    pts_t            pts;
    logic            negx;
    logic            negy;
    logic [1:0]      mode;
    logic [DENW-1:0] den;
    logic [DENW-1:0] rx;
    logic [DENW-1:0] ry;
    logic [CW-1:0]   lox;
    logic [CW-1:0]   loy;
    logic [CW-1:0]   quo_x;
    logic [CW-1:0]   quo_y;
  } div_t;

  function automatic div_t div_step(div_t a);
    div_t          o;
    logic [DENW:0] tx;
    logic [DENW:0] ty;
    logic [DENW:0] d;
    o  = a;
    d  = {1'b0, a.den};
    tx = {a.rx, a.lox[CW-1]};
    ty = {a.ry, a.loy[CW-1]};
    if (tx >= d) begin
      o.rx    = DENW'(tx - d);
      o.quo_x = {a.quo_x[CW-2:0], 1'b1};
    end else begin
      o.rx    = tx[DENW-1:0];
      o.quo_x = {a.quo_x[CW-2:0], 1'b0};
    end
    if (ty >= d) begin
      o.ry    = DENW'(ty - d);
      o.quo_y = {a.quo_y[CW-2:0], 1'b1};
    end else begin
      o.ry    = ty[DENW-1:0];
      o.quo_y = {a.quo_y[CW-2:0], 1'b0};
    end
    o.lox = {a.lox[CW-2:0], 1'b0};
    o.loy = {a.loy[CW-2:0], 1'b0};
    return o;
  endfunction
endpackage

// ===== hw/rtl/cps_front.sv =====
// front stages: differences, products, projection sums, classify and scale
// depends on cps_pkg
`timescale 1ns / 1ps
module cps_front (
  input  logic                         clk_i,
  input  logic [cps_pkg::NFRONT-1:0]   en_i,
  input  logic [cps_pkg::CW-1:0]       start_x_i,
  input  logic [cps_pkg::CW-1:0]       start_y_i,
  input  logic [cps_pkg::CW-1:0]       end_x_i,
  input  logic [cps_pkg::CW-1:0]       end_y_i,
  input  logic [cps_pkg::CW-1:0]       query_x_i,
  input  logic [cps_pkg::CW-1:0]       query_y_i,
  output cps_pkg::div_t                res_o
);
  cps_pkg::pts_t pts1_q, pts2_q, pts3_q;
  logic signed [cps_pkg::DW-1:0]   dx1_q, dy1_q, px1_q, py1_q;
  logic signed [cps_pkg::DW-1:0]   dx2_q, dy2_q, dx3_q, dy3_q;
  logic signed [2*cps_pkg::DW-1:0] pxdx2_q, pydy2_q;
  logic [cps_pkg::DENW-1:0]        dxx2_q, dyy2_q, den3_q;
  logic signed [cps_pkg::NW-1:0]   num3_q;
  logic signed [2*cps_pkg::DW-1:0] mxx, myy;
  logic [cps_pkg::CW-1:0]          adx, ady;
  logic [cps_pkg::DENW-1:0]        num_u;
  logic [cps_pkg::PW-1:0]          prod_x, prod_y;
  cps_pkg::div_t                   res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pts1_q <= '{sx: start_x_i, sy: start_y_i, ex: end_x_i, ey: end_y_i,
                  qx: query_x_i, qy: query_y_i};
      dx1_q  <= $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
      dy1_q  <= $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
      px1_q  <= $signed({1'b0, query_x_i}) - $signed({1'b0, start_x_i});
      py1_q  <= $signed({1'b0, query_y_i}) - $signed({1'b0, start_y_i});
    end
  end

  assign mxx = dx1_q * dx1_q;
  assign myy = dy1_q * dy1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pts2_q  <= pts1_q;
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      pxdx2_q <= px1_q * dx1_q;
      pydy2_q <= py1_q * dy1_q;
      dxx2_q  <= mxx[cps_pkg::DENW-1:0];
      dyy2_q  <= myy[cps_pkg::DENW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pts3_q <= pts2_q;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      num3_q <= cps_pkg::NW'(pxdx2_q) + cps_pkg::NW'(pydy2_q);
      den3_q <= dxx2_q + dyy2_q;
    end
  end

  always_comb begin
    adx    = dx3_q[cps_pkg::DW-1] ? cps_pkg::CW'(-dx3_q) : cps_pkg::CW'(dx3_q);
    ady    = dy3_q[cps_pkg::DW-1] ? cps_pkg::CW'(-dy3_q) : cps_pkg::CW'(dy3_q);
    num_u  = num3_q[cps_pkg::DENW-1:0];
    prod_x = cps_pkg::PW'(num_u) * cps_pkg::PW'(adx);
    prod_y = cps_pkg::PW'(num_u) * cps_pkg::PW'(ady);
    res_d.pts  = pts3_q;
    res_d.negx = dx3_q[cps_pkg::DW-1];
    res_d.negy = dy3_q[cps_pkg::DW-1];
    res_d.den  = den3_q;
    if (den3_q == '0 || num3_q[cps_pkg::NW-1] || num3_q == '0) begin
      res_d.mode = cps_pkg::MODE_START;
    end else if ($unsigned(num3_q) >= {{(cps_pkg::NW-cps_pkg::DENW){1'b0}}, den3_q}) begin
      res_d.mode = cps_pkg::MODE_END;
    end else begin
      res_d.mode = cps_pkg::MODE_MID;
    end
    res_d.rx    = prod_x[cps_pkg::PW-1:cps_pkg::CW];
    res_d.ry    = prod_y[cps_pkg::PW-1:cps_pkg::CW];
    res_d.lox   = prod_x[cps_pkg::CW-1:0];
    res_d.loy   = prod_y[cps_pkg::CW-1:0];
    res_d.quo_x = '0;
    res_d.quo_y = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule

// ===== hw/rtl/cps_div.sv =====
// pipelined restoring divider, one quotient bit per stage for both axes
// depends on cps_pkg
`timescale 1ns / 1ps
module cps_div (
  input  logic                   clk_i,
  input  logic [cps_pkg::CW-1:0] en_i,
  input  cps_pkg::div_t          div_i,
  output cps_pkg::div_t          div_o
);
  cps_pkg::div_t stg_q [cps_pkg::CW];

  for (genvar i = 0; i < cps_pkg::CW; i++) begin : g_stage
    cps_pkg::div_t stg_d;
    if (i == 0) begin : g_first
      assign stg_d = cps_pkg::div_step(div_i);
    end else begin : g_next
      assign stg_d = cps_pkg::div_step(stg_q[i-1]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        stg_q[i] <= stg_d;
      end
    end
  end

  assign div_o = stg_q[cps_pkg::CW-1];
endmodule

// ===== hw/rtl/cps_back.sv =====
// back stages: nearest point, squared offsets, reach compare and result register
// depends on cps_pkg
`timescale 1ns / 1ps
module cps_back (
  input  logic                       clk_i,
  input  logic [cps_pkg::NBACK-1:0]  en_i,
  input  cps_pkg::div_t              div_i,
  input  logic [cps_pkg::RW-1:0]     reach2_i,
  output logic                       within_reach_o,
  output logic [cps_pkg::CW-1:0]     nearest_x_o,
  output logic [cps_pkg::CW-1:0]     nearest_y_o
);
  logic [cps_pkg::CW-1:0]   nx_d, ny_d, nx1_q, ny1_q, qx1_q, qy1_q, nx2_q, ny2_q;
  logic [cps_pkg::CW-1:0]   adx, ady;
  logic [2*cps_pkg::CW-1:0] sqx2_q, sqy2_q;
  logic [cps_pkg::DISTW-1:0] dsum;
  logic                     ok;
  logic                     within_q;
  logic [cps_pkg::CW-1:0]   outx_q, outy_q;

  always_comb begin
    unique case (div_i.mode)
      cps_pkg::MODE_END: begin
        nx_d = div_i.pts.ex;
        ny_d = div_i.pts.ey;
      end
      cps_pkg::MODE_MID: begin
        nx_d = div_i.negx
             ? div_i.pts.sx - div_i.quo_x - cps_pkg::CW'(div_i.rx != '0)
             : div_i.pts.sx + div_i.quo_x;
        ny_d = div_i.negy
             ? div_i.pts.sy - div_i.quo_y - cps_pkg::CW'(div_i.ry != '0)
             : div_i.pts.sy + div_i.quo_y;
      end
      default: begin
        nx_d = div_i.pts.sx;
        ny_d = div_i.pts.sy;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      nx1_q <= nx_d;
      ny1_q <= ny_d;
      qx1_q <= div_i.pts.qx;
      qy1_q <= div_i.pts.qy;
    end
  end

  assign adx = (qx1_q >= nx1_q) ? qx1_q - nx1_q : nx1_q - qx1_q;
  assign ady = (qy1_q >= ny1_q) ? qy1_q - ny1_q : ny1_q - qy1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      nx2_q  <= nx1_q;
      ny2_q  <= ny1_q;
      sqx2_q <= (2*cps_pkg::CW)'(adx) * (2*cps_pkg::CW)'(adx);
      sqy2_q <= (2*cps_pkg::CW)'(ady) * (2*cps_pkg::CW)'(ady);
    end
  end

  assign dsum = cps_pkg::DISTW'(sqx2_q) + cps_pkg::DISTW'(sqy2_q);
  assign ok   = cps_pkg::CMPW'(dsum) <= cps_pkg::CMPW'(reach2_i);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      within_q <= ok;
      outx_q   <= ok ? nx2_q : '0;
      outy_q   <= ok ? ny2_q : '0;
    end
  end

  assign within_reach_o = within_q;
  assign nearest_x_o    = outx_q;
  assign nearest_y_o    = outy_q;
endmodule

// ===== hw/rtl/closest_point_on_segment.sv =====
// closest point on segment: usage
// input channel: valid_i with the six coordinates, stall_o back; an item is
// taken at a clock edge with valid_i high and stall_o low
// output channel: valid_o with within_reach_o, nearest_x_o, nearest_y_o, and
// stall_i from the receiver; a result leaves with valid_o high and stall_i low
// config: max_distance_i with cfg_valid_i; cfg_ready_o is always high, write
// only while no item is in flight
// pipeline: 23 register stages (4 front, 16 divider, 3 back)
// throughput: one item per cycle while stall_o is low; the 16-stage quotient pipeline sets depth
// reset: all stage valid bits clear, reach cleared to zero
// on stall_i the held result stays put, empty stages behind it keep filling,
// and stall_o rises only once every stage up to the output holds an item
// depends on cps_pkg, cps_front, cps_div, cps_back and the defines header
`timescale 1ns / 1ps
`include "closest_point_on_segment_defines.svh"
module closest_point_on_segment (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [cps_pkg::CW-1:0]   start_x_i,
  input  logic [cps_pkg::CW-1:0]   start_y_i,
  input  logic [cps_pkg::CW-1:0]   end_x_i,
  input  logic [cps_pkg::CW-1:0]   end_y_i,
  input  logic [cps_pkg::CW-1:0]   query_x_i,
  input  logic [cps_pkg::CW-1:0]   query_y_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic                     within_reach_o,
  output logic [cps_pkg::CW-1:0]   nearest_x_o,
  output logic [cps_pkg::CW-1:0]   nearest_y_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [cps_pkg::MDW-1:0]  max_distance_i
);
  logic [cps_pkg::NST-1:0] v_q, v_d, en;
  logic [cps_pkg::RW-1:0]  reach2_q;
  cps_pkg::div_t           front_res, div_res;

  always_comb begin
    en[cps_pkg::NST-1] = !v_q[cps_pkg::NST-1] || !stall_i;
    for (int k = cps_pkg::NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? valid_i : v_q[0];
    for (int k = 1; k < cps_pkg::NST; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      reach2_q <= '0;
    end else begin
      v_q <= v_d;
      if (cfg_valid_i) begin
        reach2_q <= cps_pkg::RW'(max_distance_i) * cps_pkg::RW'(max_distance_i);
      end
    end
  end

  assign stall_o     = !en[0];
  assign valid_o     = v_q[cps_pkg::NST-1];
  assign cfg_ready_o = 1'b1;

  cps_front u_front (
    .clk_i     (clk_i),
    .en_i      (en[cps_pkg::NFRONT-1:0]),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .query_x_i (query_x_i),
    .query_y_i (query_y_i),
    .res_o     (front_res)
  );

  cps_div u_div (
    .clk_i (clk_i),
    .en_i  (en[cps_pkg::NFRONT+cps_pkg::CW-1:cps_pkg::NFRONT]),
    .div_i (front_res),
    .div_o (div_res)
  );

  cps_back u_back (
    .clk_i          (clk_i),
    .en_i           (en[cps_pkg::NST-1:cps_pkg::NFRONT+cps_pkg::CW]),
    .div_i          (div_res),
    .reach2_i       (reach2_q),
    .within_reach_o (within_reach_o),
    .nearest_x_o    (nearest_x_o),
    .nearest_y_o    (nearest_y_o)
  );

  `CPS_ASSERT(a_far_zero, (valid_o && !within_reach_o) |-> (nearest_x_o == '0 && nearest_y_o == '0))
  `CPS_ASSERT(a_stall_full, stall_o |-> (v_q == '1 && stall_i))
  `CPS_ASSERT_NEXT(a_accept_enters, valid_i && !stall_o, v_q[0])
endmodule
